### rtl/rfr_pkg.sv
// Shared types and constants for the radio frame receiver.
// No dependencies; imported by radio_frame_receiver.
package rfr_pkg;

  localparam logic [7:0] SYNC_BYTE  = 8'hff;
  localparam int         HEADER_LEN = 4;

  // Parser positions inside a frame; data bytes follow from PH_DATA upward
  localparam int PH_SYNC = 0;
  localparam int PH_ADDR = 1;
  localparam int PH_CMD  = 2;
  localparam int PH_SIZE = 3;
  localparam int PH_DATA = 4;

  // Configuration register indexes
  typedef logic [1:0] cfg_addr_t;
  localparam cfg_addr_t REG_STATION_ADDRESS = 2'd0;
  localparam cfg_addr_t REG_COMMAND_LIMIT   = 2'd1;
  localparam cfg_addr_t REG_SIZE_LIMIT      = 2'd2;

  localparam logic [7:0] STATION_ADDRESS_RST = 8'd33;
  localparam logic [7:0] COMMAND_LIMIT_RST   = 8'd16;
  localparam logic [5:0] SIZE_LIMIT_RST      = 6'd7;

  typedef enum logic [3:0] {
    ST_RX   = 4'b0001,  // parsing incoming words
    ST_READ = 4'b0010,  // frame memory read issued
    ST_LOAD = 4'b0100,  // read data moves into the output register
    ST_BAD  = 4'b1000   // checksum mismatch result pending
  } state_t;

endpackage

### rtl/radio_frame_receiver.sv
// Radio frame receiver: byte-serial frame parser with checksum and frame memory.
// Depends on rfr_pkg.
//
// Accepts one received byte per cycle on the s_ stream unless stalled, and parses frames of the form
// 0xff, address, command, size, data[size], check_high, check_low. A 0xff word always
// restarts the frame. Header and data bytes are written to a single-port-write frame
// memory of 4 + MAX_PAYLOAD entries as they arrive while a 16-bit running sum is kept,
// so the check costs no extra time. After a good final check byte the input stalls
// while the stored frame is read back: each output word takes a memory read (ST_READ)
// and then a load of the output register (ST_LOAD), which waits while m_tready is held
// low. A checksum mismatch gives one word with m_tuser low, loaded from ST_BAD into the
// output register once that register is free. No clearing pass is needed after reset;
// configuration writes take effect on the next cycle.
module radio_frame_receiver #(
  parameter int unsigned MAX_PAYLOAD = 7
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,    // [7:0] rx_byte
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [7:0]         m_tdata,    // [7:0] out_byte
  output logic               m_tlast,    // out_last
  output logic [0:0]         m_tuser,    // [0] frame_good
  input  logic               cfg_we,
  input  rfr_pkg::cfg_addr_t cfg_addr,
  input  logic [7:0]         cfg_wdata
);
  import rfr_pkg::*;

  localparam int StoreLen = HEADER_LEN + MAX_PAYLOAD;
  localparam int AW       = $clog2(StoreLen);
  localparam int PW       = $clog2(StoreLen + 2);
  localparam int LW       = $clog2(MAX_PAYLOAD + 1);

  // configuration
  logic [7:0] station_address;
  logic [7:0] command_limit;
  logic [5:0] size_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      station_address <= STATION_ADDRESS_RST;
      command_limit   <= COMMAND_LIMIT_RST;
      size_limit      <= SIZE_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_STATION_ADDRESS: station_address <= cfg_wdata;
        REG_COMMAND_LIMIT:   command_limit   <= cfg_wdata;
        REG_SIZE_LIMIT:      size_limit      <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  // parser state
  state_t         state, state_next;
  logic [PW-1:0]  phase, phase_next;
  logic [LW-1:0]  payload_len, payload_len_next;
  logic [15:0]    sum, sum_next;
  logic [7:0]     check_high, check_high_next;
  logic [AW-1:0]  rd_idx, rd_idx_next;

  // frame memory
  logic [7:0]     frame_mem [StoreLen];
  logic [7:0]     mem_q;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;

  // output register
  logic           out_valid;
  logic [7:0]     out_byte;
  logic           out_last;
  logic           out_good;
  logic           out_free;

  logic           in_acc;
  logic [7:0]     b;
  logic [PW-1:0]  total;
  logic [5:0]     eff_lim;
  logic [15:0]    sum_adj;
  logic           drain_last;

  assign s_tready = (state == ST_RX);
  assign in_acc   = s_tvalid && s_tready;
  assign b        = s_tdata;
  assign total    = PW'(HEADER_LEN) + PW'(payload_len);
  assign eff_lim  = (size_limit > 6'(MAX_PAYLOAD)) ? 6'(MAX_PAYLOAD) : size_limit;
  assign sum_adj  = (sum[7:0] == 8'hff) ? {sum[14:0], 1'b0} : sum;
  assign out_free = !out_valid || m_tready;
  assign drain_last = (PW'(rd_idx) == total - PW'(1));

  always_comb begin
    state_next       = state;
    phase_next       = phase;
    payload_len_next = payload_len;
    sum_next         = sum;
    check_high_next  = check_high;
    rd_idx_next      = rd_idx;
    mem_we           = 1'b0;
    mem_waddr        = phase[AW-1:0];

    case (state)
      ST_RX: begin
        if (in_acc) begin
          if (b == SYNC_BYTE) begin
            mem_we     = 1'b1;
            mem_waddr  = '0;
            phase_next = PW'(PH_ADDR);
            sum_next   = 16'(SYNC_BYTE);
          end else if (phase == PW'(PH_SYNC)) begin
            // stray word while hunting for sync
          end else if (phase == PW'(PH_ADDR)) begin
            mem_we     = 1'b1;
            sum_next   = sum + 16'(b);
            phase_next = (b == station_address) ? PW'(PH_CMD) : PW'(PH_SYNC);
          end else if (phase == PW'(PH_CMD)) begin
            if (b < command_limit) begin
              mem_we     = 1'b1;
              sum_next   = sum + 16'(b);
              phase_next = PW'(PH_SIZE);
            end
          end else if (phase == PW'(PH_SIZE)) begin
            if (b != 8'd0 && b <= {2'b00, eff_lim}) begin
              mem_we           = 1'b1;
              sum_next         = sum + 16'(b);
              payload_len_next = b[LW-1:0];
              phase_next       = PW'(PH_DATA);
            end
          end else if (phase < total) begin
            mem_we     = 1'b1;
            sum_next   = sum + 16'(b);
            phase_next = phase + PW'(1);
          end else if (phase == total) begin
            check_high_next = b;
            phase_next      = phase + PW'(1);
          end else begin
            phase_next = PW'(PH_SYNC);
            if (sum_adj == {check_high, b}) begin
              rd_idx_next = '0;
              state_next  = ST_READ;
            end else begin
              state_next  = ST_BAD;
            end
          end
        end
      end
      ST_READ: state_next = ST_LOAD;
      ST_LOAD: begin
        if (out_free) begin
          if (drain_last) begin
            state_next = ST_RX;
          end else begin
            rd_idx_next = rd_idx + AW'(1);
            state_next  = ST_READ;
          end
        end
      end
      ST_BAD: begin
        if (out_free) state_next = ST_RX;
      end
      default: state_next = ST_RX;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_RX;
      phase       <= '0;
      payload_len <= '0;
      rd_idx      <= '0;
    end else begin
      state       <= state_next;
      phase       <= phase_next;
      payload_len <= payload_len_next;
      rd_idx      <= rd_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    sum        <= sum_next;
    check_high <= check_high_next;
  end

  // no write can land during readout: input is stalled outside ST_RX
  always_ff @(posedge clk) begin
    if (mem_we) frame_mem[mem_waddr] <= b;
    mem_q <= frame_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_LOAD && out_free) begin
      out_valid <= 1'b1;
    end else if (state == ST_BAD && out_free) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_LOAD && out_free) begin
      out_byte <= mem_q;
      out_last <= drain_last;
      out_good <= 1'b1;
    end else if (state == ST_BAD && out_free) begin
      out_byte <= 8'd0;
      out_last <= 1'b1;
      out_good <= 1'b0;
    end
  end

  assign m_tvalid   = out_valid;
  assign m_tdata    = out_byte;
  assign m_tlast    = out_last;
  assign m_tuser[0] = out_good;

  // checks
  a_bad_word_form: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tlast && m_tdata == 8'd0)
    else $error("mismatch word must be a single zero word with last set");

  a_phase_bound: assert property (@(posedge clk) disable iff (rst)
    phase >= PW'(PH_DATA) |-> phase <= total + PW'(1))
    else $error("parser position beyond frame end");

  a_sync_restart: assert property (@(posedge clk) disable iff (rst)
    in_acc && s_tdata == SYNC_BYTE |=> phase == PW'(PH_ADDR))
    else $error("sync word did not restart the frame");

  a_drain_index: assert property (@(posedge clk) disable iff (rst)
    state == ST_LOAD |-> PW'(rd_idx) < total)
    else $error("frame readout index past frame length");

  a_drain_len: assert property (@(posedge clk) disable iff (rst)
    state != ST_RX |-> payload_len != '0)
    else $error("readout with empty payload length");

endmodule
